FILE: rtl/mrwr_pkg.sv
package mrwr_pkg;

   localparam int WORD_BITS = 32;
   localparam int TP_BITS = 6;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int CNT_BITS = $clog2(PROD_BITS + 1);

   localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
   localparam logic [1:0] VERDICT_PASS = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_ODD_PART = 2'd1;
   localparam logic [1:0] REG_TWO_POWER = 2'd2;

   // datapath operation codes
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_MUL_ACC = 3'd2;
   localparam logic [2:0] OP_MUL_BASE = 3'd3;
   localparam logic [2:0] OP_SQR_ACC = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       shift_exp;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic exp_zero;
      logic exp_lsb;
      logic acc_is_one;
      logic acc_is_nm1;
      logic args_bad;
   } dp_sts_type;

endpackage

FILE: rtl/mrwr_datapath.sv
module mrwr_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mrwr_pkg::WORD_BITS-1:0]   modulus,
   input  logic [mrwr_pkg::WORD_BITS-1:0]   odd_part,
   input  logic [mrwr_pkg::WORD_BITS-1:0]   witness,
   input  mrwr_pkg::dp_cmd_type             cmd,
   output mrwr_pkg::dp_sts_type             sts
);
   import mrwr_pkg::*;

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 dest_acc_ff, dest_acc_in;
   logic [1:0]           phase_ff, phase_in;
   logic [WORD_BITS:0]   shifted;
   logic [WORD_BITS:0]   mod_ext;
   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   logic [WORD_BITS-1:0] nm1;

   assign mod_ext = {1'b0, modulus};
   assign nm1 = modulus - WORD_BITS'(1);
   assign shifted = {rem_ff[WORD_BITS-1:0], prod_ff[PROD_BITS-1]};

   always_comb begin
      mul_a = acc_ff;
      mul_b = base_ff;
      case (cmd.op)
         OP_MUL_ACC:  begin mul_a = acc_ff;  mul_b = base_ff; end
         OP_MUL_BASE: begin mul_a = base_ff; mul_b = base_ff; end
         OP_SQR_ACC:  begin mul_a = acc_ff;  mul_b = acc_ff;  end
         default:     begin mul_a = acc_ff;  mul_b = base_ff; end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dest_acc_in = dest_acc_ff;
      phase_in = phase_ff;
      if (cmd.shift_exp) begin
         exp_in = exp_ff >> 1;
      end
      if (busy_ff) begin
         if (phase_ff == 2'd0) begin
            // register the product, then reduce it one bit a cycle
            phase_in = 2'd1;
         end else begin
            if (shifted >= mod_ext) begin
               rem_in = shifted - mod_ext;
            end else begin
               rem_in = shifted;
            end
            prod_in = {prod_ff[PROD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if (dest_acc_ff) begin
                  acc_in = rem_in[WORD_BITS-1:0];
               end else begin
                  base_in = rem_in[WORD_BITS-1:0];
               end
            end
         end
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               acc_in = WORD_BITS'(1);
               base_in = witness;
               exp_in = odd_part;
            end
            OP_MUL_ACC, OP_MUL_BASE, OP_SQR_ACC: begin
               prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
               rem_in = '0;
               cnt_in = CNT_BITS'(PROD_BITS);
               busy_in = 1'b1;
               phase_in = 2'd1;
               dest_acc_in = (cmd.op != OP_MUL_BASE);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
      end
      acc_ff <= acc_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      dest_acc_ff <= dest_acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_lsb = exp_ff[0];
   assign sts.acc_is_one = (acc_ff == WORD_BITS'(1));
   assign sts.acc_is_nm1 = (acc_ff == nm1);
   assign sts.args_bad = (witness < WORD_BITS'(2)) || (modulus < WORD_BITS'(4))
                         || (witness > modulus - WORD_BITS'(2)) || (odd_part == '0);

endmodule

FILE: rtl/mrwr_control.sv
module mrwr_control (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_verdict,
   input  logic [mrwr_pkg::TP_BITS-1:0]   two_power,
   input  mrwr_pkg::dp_sts_type           sts,
   output mrwr_pkg::dp_cmd_type           cmd
);
   import mrwr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_EXP   = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;
   localparam logic [2:0] ST_SQR   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         ret_ff, ret_in;
   logic               mul_base_ff, mul_base_in;
   logic [TP_BITS-1:0] left_ff, left_in;
   logic [1:0]         verdict_ff, verdict_in;
   logic [1:0]         rsp_verdict_ff, rsp_verdict_in;
   logic               in_taken;
   logic               valid_ff, valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign in_taken = req_valid && req_ready;
   assign rsp_valid = valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      mul_base_in = mul_base_ff;
      left_in = left_ff;
      verdict_in = verdict_ff;
      rsp_verdict_in = rsp_verdict_ff;
      valid_in = valid_ff;
      cmd.op = OP_NONE;
      cmd.shift_exp = 1'b0;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (in_taken) begin
               cmd.op = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.args_bad) begin
               verdict_in = VERDICT_INVALID;
               state_in = ST_OUT;
            end else begin
               mul_base_in = 1'b0;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (sts.exp_zero) begin
               state_in = ST_EVAL;
            end else if (!mul_base_ff) begin
               mul_base_in = 1'b1;
               if (sts.exp_lsb) begin
                  cmd.op = OP_MUL_ACC;
                  ret_in = ST_EXP;
                  state_in = ST_WAIT;
               end
            end else begin
               // square the base and advance to the next exponent bit
               mul_base_in = 1'b0;
               cmd.op = OP_MUL_BASE;
               cmd.shift_exp = 1'b1;
               ret_in = ST_EXP;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.done) begin
               state_in = ret_ff;
            end
         end
         ST_EVAL: begin
            if (sts.acc_is_one || sts.acc_is_nm1) begin
               verdict_in = VERDICT_PASS;
               state_in = ST_OUT;
            end else begin
               verdict_in = VERDICT_COMPOSITE;
               left_in = two_power;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (left_ff <= TP_BITS'(1)) begin
               state_in = ST_OUT;
            end else begin
               left_in = left_ff - TP_BITS'(1);
               cmd.op = OP_SQR_ACC;
               ret_in = ST_SQR;
               state_in = ST_WAIT;
            end
            // a pass is checked after each square returns
            if (left_ff != two_power && sts.acc_is_nm1) begin
               verdict_in = VERDICT_PASS;
               cmd.op = OP_NONE;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free or being emptied
            if (!valid_ff || rsp_ready) begin
               valid_in = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      ret_ff <= ret_in;
      mul_base_ff <= mul_base_in;
      left_ff <= left_in;
      verdict_ff <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

endmodule

FILE: rtl/miller_rabin_witness_round_core.sv
// One Miller-Rabin round per witness against the odd candidate held in the
// modulus, odd_part and two_power registers (byte addresses 0, 4, 8). Each
// witness yields one verdict: 0 composite, 1 passes, 2 invalid witness or
// configuration. Every modular product is formed by one 32x32 multiply and
// reduced by a shared restoring remainder unit, one product bit at a time.
// One witness is processed at a time, but a finished verdict waits in its
// own register, so the next witness can transfer while it is held;
// configure only while idle.
module miller_rabin_witness_round_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_witness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mrwr_pkg::*;

   logic [WORD_BITS-1:0] modulus_ff;
   logic [WORD_BITS-1:0] odd_part_ff;
   logic [TP_BITS-1:0]   two_power_ff;
   logic [WORD_BITS-1:0] witness_ff;
   logic                 wr_en;
   logic [1:0]           reg_sel;
   dp_cmd_type           cmd;
   dp_sts_type           sts;

   assign pready = 1'b1;
   assign reg_sel = paddr[3:2];
   assign wr_en = psel && penable && pwrite;

   // hold the register file; writes land on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         odd_part_ff <= '0;
         two_power_ff <= '0;
      end else if (wr_en && paddr[1:0] == 2'b00) begin
         case (reg_sel)
            REG_MODULUS:   modulus_ff <= pwdata;
            REG_ODD_PART:  odd_part_ff <= pwdata;
            REG_TWO_POWER: two_power_ff <= pwdata[TP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MODULUS:   prdata = modulus_ff;
         REG_ODD_PART:  prdata = odd_part_ff;
         REG_TWO_POWER: prdata = {26'd0, two_power_ff};
         default:       prdata = '0;
      endcase
   end

   // capture the witness on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         witness_ff <= req_witness;
      end
   end

   mrwr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .modulus  (modulus_ff),
      .odd_part (odd_part_ff),
      .witness  ((req_valid && req_ready) ? req_witness : witness_ff),
      .cmd      (cmd),
      .sts      (sts)
   );

   mrwr_control u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .two_power   (two_power_ff),
      .sts         (sts),
      .cmd         (cmd)
   );

endmodule

FILE: tb/mrwr_checker.sv
module mrwr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_witness,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_verdict,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);
   import mrwr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] cand_n;
   logic [31:0] cand_m;
   logic [5:0]  cand_t;
   logic [1:0]  verdicts_due[$];

   // one round for witness a against the current candidate
   function automatic logic [1:0] round_verdict(logic [31:0] a, logic [31:0] n,
                                                logic [31:0] m, logic [5:0] t);
      logic [63:0] acc;
      logic [63:0] base;
      logic [63:0] nn;
      logic [31:0] e;
      logic [1:0]  v;
      nn = {32'd0, n};
      if (a < 2 || n < 4 || {32'd0, a} > nn - 2 || m == 0)
         return VERDICT_INVALID;
      acc = 1;
      base = {32'd0, a};
      e = m;
      while (e != 0) begin
         if (e[0])
            acc = (acc * base) % nn;
         e = e >> 1;
         base = (base * base) % nn;
      end
      if (acc == 1 || acc == nn - 1)
         return VERDICT_PASS;
      v = VERDICT_COMPOSITE;
      for (int j = 1; j < t; j++) begin
         acc = (acc * acc) % nn;
         if (acc == nn - 1) begin
            v = VERDICT_PASS;
            break;
         end
      end
      return v;
   endfunction

   assign pending = verdicts_due.size();

   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         cand_n <= '0;
         cand_m <= '0;
         cand_t <= '0;
         verdicts_due.delete();
         mismatches <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_MODULUS:   cand_n <= pwdata;
               REG_ODD_PART:  cand_m <= pwdata;
               REG_TWO_POWER: cand_t <= pwdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            verdicts_due.push_back(round_verdict(req_witness, cand_n, cand_m, cand_t));
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected verdict %0d with nothing outstanding", rsp_verdict);
               mismatches <= mismatches + 1;
            end else begin
               want = verdicts_due.pop_front();
               if (want !== rsp_verdict) begin
                  if (mismatches < 10)
                     $display("verdict mismatch: expected %0d, got %0d", want, rsp_verdict);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import mrwr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_witness;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          mismatches;
   int          pending;
   logic        steady;     // no idling on either side while set
   logic        hold_req;   // ask the receiver for one long hold-off
   int          sent;

   miller_rabin_witness_round_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   mrwr_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall limit: a timeout that reports an error, with ample margin for
   // full-width rounds with long squaring chains.
   initial begin
      #200_000_000;
      $display("[miller_rabin_witness_round_core] ERROR");
      $finish;
   end

   // Receiver: takes results at random (always while steady), or on request
   // holds off one long stretch so the sender backs up behind a full block.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= steady ? 1'b1 : ($urandom_range(99, 0) >= 33);
         end
      end
   end

   // One register write: setup cycle, then access cycle. Entered and left
   // on a falling edge.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drop valid, drain every outstanding verdict, then wait a quiet stretch
   // before touching the registers.
   task automatic drain_then_configure(logic [31:0] n, logic [31:0] m, logic [5:0] t);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_write(REG_MODULUS, n);
      csr_write(REG_ODD_PART, m);
      csr_write(REG_TWO_POWER, {26'd0, t});
   endtask

   // Offer one witness, after a random gap unless steady; hold valid and payload until the transfer.
   task automatic send_witness(logic [31:0] a);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99, 0) < 33)
         gap = $urandom_range(6, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_witness <= a;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   // Random odd candidate of a random width, mostly small to keep rounds
   // short; usually with a consistent m and t, sometimes arbitrary ones.
   task automatic configure_random(output logic [31:0] n_out);
      int          bits;
      logic [31:0] n;
      logic [31:0] q;
      logic [5:0]  t;
      bits = ($urandom_range(99, 0) < 70) ? $urandom_range(12, 3) : $urandom_range(32, 13);
      n = $urandom;
      if (bits < 32)
         n = n & ((32'd1 << bits) - 1);
      n = n | (32'd1 << (bits - 1)) | 32'd1;
      q = n - 1;
      t = 0;
      while (!q[0]) begin
         q = q >> 1;
         t++;
      end
      if ($urandom_range(7, 0) == 0) begin
         q = $urandom;
         t = 6'($urandom_range(63, 0));
      end
      drain_then_configure(n, q, t);
      n_out = n;
   endtask

   // Mostly valid witnesses, the rest on or beyond the range edges.
   task automatic send_random_witness(logic [31:0] n);
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 85)       send_witness($urandom_range(n - 2, 2));
      else if (pick < 88)  send_witness(32'd0);
      else if (pick < 91)  send_witness(32'd1);
      else if (pick < 94)  send_witness(n - 1);
      else if (pick < 97)  send_witness(n);
      else                 send_witness($urandom);
   endtask

   initial begin
      logic [31:0] n_now;
      int          burst;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_witness = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      steady      = 1'b0;
      hold_req    = 1'b0;
      sent        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Registers still at reset: no witness can be valid.
      send_witness(32'd0);
      send_witness(32'd1);
      send_witness(32'hFFFF_FFFF);
      send_witness(32'd2);

      // Carmichael number 561 = 2^4 * 35 + 1; witnesses at and past the edges.
      drain_then_configure(32'd561, 32'd35, 6'd4);
      send_witness(32'd2);
      send_witness(32'd50);
      send_witness(32'd559);
      send_witness(32'd560);
      send_witness(32'd1);

      // Largest 32-bit prime, t = 1 so no squaring.
      drain_then_configure(32'd4294967291, 32'd2147483645, 6'd1);
      send_witness(32'd2);
      send_witness(32'd4294967289);
      send_witness(32'd4294967290);

      // Full-width, inconsistent configuration with the largest two_power.
      drain_then_configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      send_witness(32'd2);
      send_witness(32'hFFFF_FFFD);

      // Odd part zero.
      drain_then_configure(32'd97, 32'd0, 6'd5);
      send_witness(32'd3);

      // Modulus below four never admits a witness.
      drain_then_configure(32'd3, 32'd1, 6'd1);
      send_witness(32'd2);

      // Smallest modulus with a valid witness, t zero.
      drain_then_configure(32'd4, 32'd3, 6'd0);
      send_witness(32'd2);

      // Prime 97 = 2^5 * 3 + 1, then with two_power set to 32.
      drain_then_configure(32'd97, 32'd3, 6'd5);
      send_witness(32'd2);
      send_witness(32'd5);
      send_witness(32'd95);
      drain_then_configure(32'd97, 32'd3, 6'd32);
      send_witness(32'd10);

      // Random phases. The first one starts with a long receiver hold-off
      // while witnesses keep coming; one later phase runs without idling.
      burst = 0;
      while (sent < 170) begin
         configure_random(n_now);
         if (burst == 0)
            hold_req = 1'b1;
         steady = (burst == 3);
         repeat ($urandom_range(16, 8)) send_random_witness(n_now);
         steady = 1'b0;
         burst++;
      end
      req_valid <= 1'b0;

      // Wait out the remaining verdicts, then a quiet tail.
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("[miller_rabin_witness_round_core] OK");
      else
         $display("[miller_rabin_witness_round_core] ERROR");
      $finish;
   end

endmodule
